// ===== rtl/core/wlf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wlf_pkg: shared types and constants of the weighted line fit
// Request structs of the serial multiplier and the divider, status codes.
// ----------------------------------------------------------------------------
package wlf_pkg;

	// operand widths of the shared arithmetic units
	localparam int MUL_AW  = 66;
	localparam int MUL_BW  = 96;
	localparam int DIG_W   = 16;
	localparam int NDIG_W  = 3;
	localparam int WIDE_W  = 128;

	// unit weight in q16.16
	localparam logic [31:0] ONE_Q16 = 32'h0001_0000;

	// fit status codes
	localparam logic [1:0] FIT_OK    = 2'd0;
	localparam logic [1:0] FIT_DEGEN = 2'd1;
	localparam logic [1:0] FIT_SAT   = 2'd2;

	// multiplier request: product of a and the low ndig digits of b
	typedef struct packed {
		logic                 go;
		logic [MUL_AW-1:0]    a;
		logic [MUL_BW-1:0]    b;
		logic [NDIG_W-1:0]    ndig;
	} mul_req_t;

	// divider request: unsigned num / den
	typedef struct packed {
		logic                 go;
		logic [WIDE_W-1:0]    num;
		logic [WIDE_W-1:0]    den;
	} div_req_t;

endpackage

// ===== rtl/core/wlf_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wlf_mul: digit-serial unsigned multiplier
// Multiplies a 66-bit operand by one 16-bit digit of the second operand per
// cycle, most significant digit first, into a 128-bit accumulator.
// ----------------------------------------------------------------------------
module wlf_mul (
	input  logic                            clk,
	input  logic                            arst_n,
	input  wlf_pkg::mul_req_t               req,
	output logic                            done,
	output logic [wlf_pkg::WIDE_W-1:0]      prod
);

	logic [wlf_pkg::MUL_AW-1:0]             a_q;
	logic [wlf_pkg::MUL_BW-1:0]             b_q;
	logic [wlf_pkg::NDIG_W-1:0]             k_q;
	logic                                   run_q;
	logic                                   done_q;
	logic [wlf_pkg::WIDE_W-1:0]             acc_q;
	logic [wlf_pkg::DIG_W-1:0]              dig;
	logic [wlf_pkg::MUL_AW+wlf_pkg::DIG_W-1:0] pp;
	logic [wlf_pkg::WIDE_W-1:0]             acc_next;

	// current digit and partial product
	assign dig      = b_q[{k_q, 4'b0000} +: wlf_pkg::DIG_W];
	assign pp       = a_q * dig;
	assign acc_next = {acc_q[wlf_pkg::WIDE_W-wlf_pkg::DIG_W-1:0], {wlf_pkg::DIG_W{1'b0}}}
		+ {{(wlf_pkg::WIDE_W-wlf_pkg::MUL_AW-wlf_pkg::DIG_W){1'b0}}, pp};

	// sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			k_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				run_q <= 1'b1;
				k_q   <= req.ndig - 1'b1;
			end else if (run_q) begin
				if (k_q == '0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end else begin
					k_q <= k_q - 1'b1;
				end
			end
		end
	end

	// operands and accumulator
	always_ff @(posedge clk) begin
		if (req.go) begin
			a_q   <= req.a;
			b_q   <= req.b;
			acc_q <= '0;
		end else if (run_q) begin
			acc_q <= acc_next;
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

// ===== rtl/core/wlf_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wlf_div: restoring radix-2 divider
// Unsigned 128-bit by 128-bit division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wlf_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  wlf_pkg::div_req_t               req,
	output logic                            done,
	output logic [wlf_pkg::WIDE_W-1:0]      quot
);

	localparam int W  = wlf_pkg::WIDE_W;
	localparam int CW = $clog2(W);

	logic [W-1:0]  n_q;
	logic [W-1:0]  d_q;
	logic [W:0]    r_q;
	logic [W-1:0]  q_q;
	logic [CW-1:0] cnt_q;
	logic          run_q;
	logic          done_q;
	logic [W:0]    trial;
	logic          ge;

	// shift in the next dividend bit and try the subtract
	assign trial = {r_q[W-1:0], n_q[W-1]};
	assign ge    = trial >= {1'b0, d_q};

	// sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				run_q <= 1'b1;
				cnt_q <= '1;
			end else if (run_q) begin
				if (cnt_q == '0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.go) begin
			n_q <= req.num;
			d_q <= req.den;
			r_q <= '0;
			q_q <= '0;
		end else if (run_q) begin
			n_q <= {n_q[W-2:0], 1'b0};
			r_q <= ge ? (trial - {1'b0, d_q}) : trial;
			q_q <= {q_q[W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = q_q;

endmodule

// ===== rtl/core/weighted_line_fit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weighted_line_fit: weighted least-squares straight-line fit
// Loads (x, y, weight) points and fits y = slope*x + intercept in q16.16,
// with the weighted rms residual and a status code.
// ----------------------------------------------------------------------------
// A point is taken when start is high and busy is low. Loading one point
// keeps the block busy while it forms two signed products on the shared
// 16-bit-digit multiplier, so no new point is taken until both are done.
// A request with point_last starts the fit over the N points held, which
// runs on the same multiplier and a one-bit-per-cycle divider: a check
// state, the centered-sum pass, the residual pass, a multiply for the
// intercept, four divides, a 32-step square root and a result state.
// The fit ends sooner when it is degenerate or the residual saturates.
// The result appears for one cycle with done high; it cannot be held off,
// so capture it then. Points beyond MAX_POINTS are dropped. The use_weights
// register is written on the cfg channel, which is always ready, and
// applies to points loaded after the write.
// ----------------------------------------------------------------------------
module weighted_line_fit #(
	parameter int MAX_POINTS = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] x_value,
	input  logic signed [31:0] y_value,
	input  logic [31:0]        weight,
	input  logic               point_last,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_data,
	output logic               done,
	output logic signed [31:0] slope,
	output logic signed [31:0] intercept,
	output logic [31:0]        rms_residual,
	output logic [1:0]         fit_status
);

	localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CW = $clog2(MAX_POINTS + 1);
	localparam int W  = wlf_pkg::WIDE_W;

	typedef enum logic [19:0] {
		S_IDLE   = 20'h00001,
		S_LDX    = 20'h00002,
		S_LDY    = 20'h00004,
		S_CHK    = 20'h00008,
		S_XMEAN  = 20'h00010,
		S_P1RD   = 20'h00020,
		S_P1WDX  = 20'h00040,
		S_P1NUM  = 20'h00080,
		S_P1DEN  = 20'h00100,
		S_P1END  = 20'h00200,
		S_SLOPE  = 20'h00400,
		S_ICMUL  = 20'h00800,
		S_ICDIV  = 20'h01000,
		S_P2RD   = 20'h02000,
		S_P2SX   = 20'h04000,
		S_P2SQ   = 20'h08000,
		S_P2W    = 20'h10000,
		S_RMSDIV = 20'h20000,
		S_SQRT   = 20'h40000,
		S_OUT    = 20'h80000
	} state_t;

	// truncated quotient clamped to signed 32 bits, {clamped, value}
	function automatic logic [32:0] div_sat(input logic neg, input logic [W-1:0] q);
		logic [31:0] lim;
		logic [31:0] m;
		logic        over;
		lim  = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
		over = (q[W-1:32] != '0) || (q[31:0] > lim);
		m    = over ? lim : q[31:0];
		return {over, neg ? (~m + 32'd1) : m};
	endfunction

	// two's complement negate when s is set
	function automatic logic [W-1:0] apply_sign(input logic s, input logic [W-1:0] v);
		return s ? (~v + 1'b1) : v;
	endfunction

	state_t                 state_q;
	logic                   use_w_q;
	logic [CW-1:0]          cnt_q;
	logic [CW-1:0]          i_q;
	logic                   sent_q;
	logic                   last_q;
	logic [47:0]            sumw_q;
	logic [63:0]            sumx_q;
	logic [63:0]            sumy_q;
	logic [31:0]            x_q;
	logic [31:0]            y_q;
	logic [31:0]            w_q;
	logic [95:0]            mem [MAX_POINTS];
	logic [95:0]            rd_q;
	logic [31:0]            xmean_q;
	logic [W-1:0]           num_q;
	logic [W-1:0]           den_q;
	logic [65:0]            wdx_q;
	logic [31:0]            slope_q;
	logic [31:0]            icpt_q;
	logic [W-1:0]           icn_q;
	logic [48:0]            dy_q;
	logic [95:0]            sq_q;
	logic [W-1:0]           res_q;
	logic                   sat_q;
	logic [63:0]            sv_q;
	logic [63:0]            sres_q;
	logic [63:0]            sbit_q;
	logic [31:0]            rms_q;
	logic [1:0]             status_q;

	wlf_pkg::mul_req_t      mreq;
	wlf_pkg::div_req_t      dreq;
	logic                   mul_done;
	logic [W-1:0]           mul_p;
	logic                   div_done;
	logic [W-1:0]           div_q;
	logic                   is_mul;
	logic                   is_div;
	logic                   accept;
	logic                   full;
	logic [31:0]            w_eff;
	logic [31:0]            rd_x;
	logic [31:0]            rd_y;
	logic [31:0]            rd_w;
	logic [33:0]            dx;
	logic [33:0]            dx_mag;
	logic [31:0]            x_mag;
	logic [31:0]            y_mag;
	logic [31:0]            rdy_mag;
	logic [31:0]            rdx_mag;
	logic [31:0]            slope_mag;
	logic [63:0]            sumx_mag;
	logic [W-1:0]           num_mag;
	logic [W-1:0]           icn_mag;
	logic [47:0]            dy_mag;
	logic                   div_neg;
	logic [32:0]            dsat;
	logic [63:0]            ldp;
	logic [63:0]            ld_floor;
	logic [63:0]            sxp;
	logic [63:0]            sx_floor;
	logic [63:0]            dy_full;
	logic [W:0]             res_sum;
	logic [63:0]            sq_try;
	logic                   sq_ge;
	logic [63:0]            sres_next;
	logic                   last_pt;

	// handshake
	assign busy      = (state_q != S_IDLE);
	assign accept    = start && !busy;
	assign cfg_ready = 1'b1;
	assign full      = (cnt_q == CW'(MAX_POINTS));
	assign w_eff     = use_w_q ? weight : wlf_pkg::ONE_Q16;
	assign last_pt   = ((i_q + 1'b1) == cnt_q);

	// fields of the stored point under the pass counter
	assign rd_x = rd_q[31:0];
	assign rd_y = rd_q[63:32];
	assign rd_w = rd_q[95:64];

	// magnitudes and centered x
	assign x_mag     = x_q[31] ? (~x_q + 32'd1) : x_q;
	assign y_mag     = y_q[31] ? (~y_q + 32'd1) : y_q;
	assign rdx_mag   = rd_x[31] ? (~rd_x + 32'd1) : rd_x;
	assign rdy_mag   = rd_y[31] ? (~rd_y + 32'd1) : rd_y;
	assign slope_mag = slope_q[31] ? (~slope_q + 32'd1) : slope_q;
	assign sumx_mag  = sumx_q[63] ? (~sumx_q + 64'd1) : sumx_q;
	assign num_mag   = num_q[W-1] ? (~num_q + 1'b1) : num_q;
	assign icn_mag   = icn_q[W-1] ? (~icn_q + 1'b1) : icn_q;
	assign dx        = {{2{rd_x[31]}}, rd_x} - {{2{xmean_q[31]}}, xmean_q};
	assign dx_mag    = dx[33] ? (~dx + 34'd1) : dx;
	assign dy_mag    = dy_q[48] ? 48'(~dy_q + 49'd1) : dy_q[47:0];

	// floored q16.16 products for the load sums and the residual pass
	assign ldp      = mul_p[63:0];
	assign ld_floor = 64'($signed((x_q[31] && (state_q == S_LDX)) ||
		(y_q[31] && (state_q == S_LDY)) ? (~ldp + 64'd1) : ldp) >>> 16);
	assign sxp      = (rd_x[31] ^ slope_q[31]) ? (~mul_p[63:0] + 64'd1) : mul_p[63:0];
	assign sx_floor = 64'($signed(sxp) >>> 16);
	assign dy_full  = {{32{rd_y[31]}}, rd_y} - {{32{icpt_q[31]}}, icpt_q} - sx_floor;
	assign res_sum  = {1'b0, res_q} + {1'b0, mul_p};

	// square root step
	assign sq_try    = sres_q + sbit_q;
	assign sq_ge     = sv_q >= sq_try;
	assign sres_next = sq_ge ? ((sres_q >> 1) + sbit_q) : (sres_q >> 1);

	// multiplier request per state
	always_comb begin
		mreq   = '0;
		is_mul = 1'b1;
		case (state_q)
			S_LDX: begin
				mreq.a    = 66'(x_mag);
				mreq.b    = 96'(w_q);
				mreq.ndig = 3'd2;
			end
			S_LDY: begin
				mreq.a    = 66'(y_mag);
				mreq.b    = 96'(w_q);
				mreq.ndig = 3'd2;
			end
			S_P1WDX: begin
				mreq.a    = 66'(dx_mag);
				mreq.b    = 96'(rd_w);
				mreq.ndig = 3'd2;
			end
			S_P1NUM: begin
				mreq.a    = wdx_q;
				mreq.b    = 96'(rdy_mag);
				mreq.ndig = 3'd2;
			end
			S_P1DEN: begin
				mreq.a    = wdx_q;
				mreq.b    = 96'(dx_mag);
				mreq.ndig = 3'd3;
			end
			S_ICMUL: begin
				mreq.a    = 66'(sumx_mag);
				mreq.b    = 96'(slope_mag);
				mreq.ndig = 3'd2;
			end
			S_P2SX: begin
				mreq.a    = 66'(rdx_mag);
				mreq.b    = 96'(slope_mag);
				mreq.ndig = 3'd2;
			end
			S_P2SQ: begin
				mreq.a    = 66'(dy_mag);
				mreq.b    = 96'(dy_mag);
				mreq.ndig = 3'd3;
			end
			S_P2W: begin
				mreq.a    = 66'(rd_w);
				mreq.b    = sq_q;
				mreq.ndig = 3'd6;
			end
			default: begin
				is_mul = 1'b0;
			end
		endcase
		mreq.go = is_mul && !sent_q;
	end

	// divider request per state
	always_comb begin
		dreq    = '0;
		is_div  = 1'b1;
		div_neg = 1'b0;
		case (state_q)
			S_XMEAN: begin
				dreq.num = {48'd0, sumx_mag, 16'd0};
				dreq.den = W'(sumw_q);
				div_neg  = sumx_q[63];
			end
			S_SLOPE: begin
				dreq.num = {num_mag[W-17:0], 16'd0};
				dreq.den = den_q;
				div_neg  = num_q[W-1];
			end
			S_ICDIV: begin
				dreq.num = icn_mag;
				dreq.den = W'(sumw_q);
				div_neg  = icn_q[W-1];
			end
			S_RMSDIV: begin
				dreq.num = res_q;
				dreq.den = W'(sumw_q);
			end
			default: begin
				is_div = 1'b0;
			end
		endcase
		dreq.go = is_div && !sent_q;
	end

	assign dsat = div_sat(div_neg, div_q);

	// shared arithmetic units
	wlf_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.done   (mul_done),
		.prod   (mul_p)
	);

	wlf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.done   (div_done),
		.quot   (div_q)
	);

	// point store
	always_ff @(posedge clk) begin
		if (accept && !full) begin
			mem[cnt_q[AW-1:0]] <= {w_eff, y_value, x_value};
		end
		rd_q <= mem[i_q[AW-1:0]];
	end

	// sequencer and set sums
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			use_w_q <= 1'b0;
			cnt_q   <= '0;
			i_q     <= '0;
			sent_q  <= 1'b0;
			last_q  <= 1'b0;
			sumw_q  <= '0;
			sumx_q  <= '0;
			sumy_q  <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				use_w_q <= cfg_data;
			end
			if (mreq.go || dreq.go) begin
				sent_q <= 1'b1;
			end else if (mul_done || div_done) begin
				sent_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						last_q <= point_last;
						if (!full) begin
							cnt_q   <= cnt_q + 1'b1;
							state_q <= S_LDX;
						end else if (point_last) begin
							state_q <= S_CHK;
						end
					end
				end
				S_LDX: begin
					if (mul_done) begin
						sumw_q  <= sumw_q + 48'(w_q);
						sumx_q  <= sumx_q + ld_floor;
						state_q <= S_LDY;
					end
				end
				S_LDY: begin
					if (mul_done) begin
						sumy_q  <= sumy_q + ld_floor;
						state_q <= last_q ? S_CHK : S_IDLE;
					end
				end
				S_CHK: begin
					i_q     <= '0;
					state_q <= (sumw_q == '0) ? S_OUT : S_XMEAN;
				end
				S_XMEAN: begin
					if (div_done) begin
						state_q <= S_P1RD;
					end
				end
				S_P1RD: begin
					state_q <= S_P1WDX;
				end
				S_P1WDX: begin
					if (mul_done) begin
						state_q <= S_P1NUM;
					end
				end
				S_P1NUM: begin
					if (mul_done) begin
						state_q <= S_P1DEN;
					end
				end
				S_P1DEN: begin
					if (mul_done) begin
						if (last_pt) begin
							state_q <= S_P1END;
						end else begin
							i_q     <= i_q + 1'b1;
							state_q <= S_P1RD;
						end
					end
				end
				S_P1END: begin
					state_q <= (den_q == '0) ? S_OUT : S_SLOPE;
				end
				S_SLOPE: begin
					if (div_done) begin
						state_q <= S_ICMUL;
					end
				end
				S_ICMUL: begin
					if (mul_done) begin
						state_q <= S_ICDIV;
					end
				end
				S_ICDIV: begin
					if (div_done) begin
						i_q     <= '0;
						state_q <= S_P2RD;
					end
				end
				S_P2RD: begin
					state_q <= S_P2SX;
				end
				S_P2SX: begin
					if (mul_done) begin
						state_q <= S_P2SQ;
					end
				end
				S_P2SQ: begin
					if (mul_done) begin
						state_q <= S_P2W;
					end
				end
				S_P2W: begin
					if (mul_done) begin
						if (last_pt) begin
							state_q <= S_RMSDIV;
						end else begin
							i_q     <= i_q + 1'b1;
							state_q <= S_P2RD;
						end
					end
				end
				S_RMSDIV: begin
					if (div_done) begin
						state_q <= (div_q[W-1:64] != '0) ? S_OUT : S_SQRT;
					end
				end
				S_SQRT: begin
					if (sbit_q[0]) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					cnt_q   <= '0;
					sumw_q  <= '0;
					sumx_q  <= '0;
					sumy_q  <= '0;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// fit datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					x_q <= x_value;
					y_q <= y_value;
					w_q <= w_eff;
				end
			end
			S_CHK: begin
				num_q    <= '0;
				den_q    <= '0;
				res_q    <= '0;
				sat_q    <= 1'b0;
				slope_q  <= '0;
				icpt_q   <= '0;
				rms_q    <= '0;
				status_q <= wlf_pkg::FIT_DEGEN;
			end
			S_XMEAN: begin
				if (div_done) begin
					xmean_q <= dsat[31:0];
				end
			end
			S_P1WDX: begin
				if (mul_done) begin
					wdx_q <= mul_p[65:0];
				end
			end
			S_P1NUM: begin
				if (mul_done) begin
					num_q <= num_q + apply_sign(dx[33] ^ rd_y[31], mul_p);
				end
			end
			S_P1DEN: begin
				if (mul_done) begin
					den_q <= den_q + mul_p;
				end
			end
			S_SLOPE: begin
				if (div_done) begin
					slope_q <= dsat[31:0];
					sat_q   <= sat_q | dsat[32];
				end
			end
			S_ICMUL: begin
				if (mul_done) begin
					icn_q <= {{48{sumy_q[63]}}, sumy_q, 16'd0}
						- apply_sign(slope_q[31] ^ sumx_q[63], mul_p);
				end
			end
			S_ICDIV: begin
				if (div_done) begin
					icpt_q <= dsat[31:0];
					sat_q  <= sat_q | dsat[32];
				end
			end
			S_P2SX: begin
				if (mul_done) begin
					dy_q <= dy_full[48:0];
				end
			end
			S_P2SQ: begin
				if (mul_done) begin
					sq_q <= mul_p[95:0];
				end
			end
			S_P2W: begin
				if (mul_done) begin
					res_q <= res_sum[W] ? '1 : res_sum[W-1:0];
				end
			end
			S_RMSDIV: begin
				if (div_done) begin
					sv_q     <= div_q[63:0];
					sres_q   <= '0;
					sbit_q   <= 64'h4000_0000_0000_0000;
					rms_q    <= '1;
					status_q <= wlf_pkg::FIT_SAT;
				end
			end
			S_SQRT: begin
				if (sq_ge) begin
					sv_q <= sv_q - sq_try;
				end
				sres_q <= sres_next;
				sbit_q <= sbit_q >> 2;
				if (sbit_q[0]) begin
					rms_q    <= sres_next[31:0];
					status_q <= sat_q ? wlf_pkg::FIT_SAT : wlf_pkg::FIT_OK;
				end
			end
			S_P1END: begin
				if (den_q == '0) begin
					status_q <= wlf_pkg::FIT_DEGEN;
				end
			end
			default: begin
			end
		endcase
	end

	// result ports
	assign done         = (state_q == S_OUT);
	assign slope        = slope_q;
	assign intercept    = icpt_q;
	assign rms_residual = rms_q;
	assign fit_status   = status_q;

	// checks
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy)
		else $error("block not idle after result");

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && fit_status == wlf_pkg::FIT_DEGEN) |->
		(slope == 32'sd0 && intercept == 32'sd0 && rms_residual == 32'd0))
		else $error("degenerate result with nonzero fields");

	a_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !full) |=> busy)
		else $error("stored point not loaded");

	a_single_unit: assert property (@(posedge clk) disable iff (!arst_n)
		!(mreq.go && dreq.go))
		else $error("multiplier and divider launched together");

endmodule

// ===== dv/wlf_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wlf_checker: result predictor and scoreboard for the weighted line fit
// Watches the point, cfg and result channels, keeps its own copy of the point
// set and the weight mode, predicts each fit and compares it field by field.
// ----------------------------------------------------------------------------
module wlf_checker #(
	parameter int MAX_POINTS = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic signed [31:0] x_value,
	input  logic signed [31:0] y_value,
	input  logic [31:0]        weight,
	input  logic               point_last,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic               cfg_data,
	input  logic               done,
	input  logic signed [31:0] slope,
	input  logic signed [31:0] intercept,
	input  logic [31:0]        rms_residual,
	input  logic [1:0]         fit_status,
	output int                 errors,
	output int                 pending
);

	typedef struct packed {
		logic [31:0] slope;
		logic [31:0] icpt;
		logic [31:0] rms;
		logic [1:0]  status;
	} fit_t;

	// model copy of the point set
	logic signed [31:0] px [MAX_POINTS];
	logic signed [31:0] py [MAX_POINTS];
	logic [31:0]        pw [MAX_POINTS];
	int                 npts;
	logic [63:0]        acc_w;
	logic signed [63:0] acc_wx;
	logic signed [63:0] acc_wy;
	logic               unit_mode_off;
	bit                 clamp_hit;
	fit_t               fit_queue [$];

	function automatic logic [63:0] mag(input logic signed [63:0] v);
		return v < 0 ? -v : v;
	endfunction

	// truncating signed divide by a positive value, clamped to 32 bits
	function automatic logic signed [63:0] div_clamp(input logic [127:0] n,
			input logic [127:0] d);
		logic        neg;
		logic [127:0] m;
		logic [127:0] q;
		logic [63:0] lim;
		neg = n[127];
		m = neg ? -n : n;
		q = m / d;
		lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
		if (q > {64'b0, lim}) begin
			q = {64'b0, lim};
			clamp_hit = 1'b1;
		end
		return neg ? -$signed(q[63:0]) : $signed(q[63:0]);
	endfunction

	function automatic logic [63:0] isqrt(input logic [63:0] v);
		logic [63:0] res;
		logic [63:0] b;
		res = 0;
		b = 64'h4000_0000_0000_0000;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v = v - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	// full fit over the points held
	function automatic fit_t fit_line();
		fit_t               r;
		logic [127:0]       wsum, num, den, acc, p, t, s, q;
		logic signed [63:0] xmean, sl, ic, dx, yv, dy;
		logic [63:0]        wdx, m;
		r = '{slope: 0, icpt: 0, rms: 0, status: wlf_pkg::FIT_DEGEN};
		if (acc_w == 0) return r;
		wsum = {64'b0, acc_w};
		num = 0;
		den = 0;
		acc = 0;
		xmean = div_clamp({{64{acc_wx[63]}}, acc_wx} << 16, wsum);
		clamp_hit = 1'b0;
		for (int i = 0; i < npts; i++) begin
			dx = 64'(px[i]) - xmean;
			yv = 64'(py[i]);
			wdx = {32'b0, pw[i]} * mag(dx);
			p = {64'b0, wdx} * {64'b0, mag(yv)};
			num = num + (((dx < 0) != (yv < 0)) ? -p : p);
			den = den + {64'b0, wdx} * {64'b0, mag(dx)};
		end
		if (den == 0) return r;
		sl = div_clamp(num << 16, den);
		p = {64'b0, mag(sl)} * {64'b0, mag(acc_wx)};
		if ((sl < 0) != (acc_wx < 0)) p = -p;
		ic = div_clamp(({{64{acc_wy[63]}}, acc_wy} << 16) - p, wsum);
		// residual pass, sum saturates at the full width
		for (int i = 0; i < npts; i++) begin
			dy = 64'(py[i]) - ic - ((sl * 64'(px[i])) >>> 16);
			m = mag(dy);
			t = ({64'b0, m} * {64'b0, m}) * {96'b0, pw[i]};
			s = acc + t;
			if (s < acc) s = '1;
			acc = s;
		end
		q = acc / wsum;
		if (q[127:64] != 0) begin
			r.rms = 32'hFFFF_FFFF;
			clamp_hit = 1'b1;
		end else begin
			r.rms = 32'(isqrt(q[63:0]));
		end
		r.slope = sl[31:0];
		r.icpt = ic[31:0];
		r.status = clamp_hit ? wlf_pkg::FIT_SAT : wlf_pkg::FIT_OK;
		return r;
	endfunction

	// track requests and compare results
	always @(posedge clk or negedge arst_n) begin
		logic [31:0]        w_eff;
		logic signed [63:0] xl, yl, wl;
		fit_t               exp_fit;
		if (!arst_n) begin
			acc_w = 0;
			acc_wx = 0;
			acc_wy = 0;
			npts = 0;
			unit_mode_off = 1'b0;
			errors = 0;
			fit_queue.delete();
			pending = 0;
		end else begin
			if (cfg_valid && cfg_ready) unit_mode_off = cfg_data;
			if (done) begin
				if (fit_queue.size() == 0) begin
					errors++;
					if (errors <= 10) $display("unexpected result at %0t", $realtime);
				end else begin
					exp_fit = fit_queue.pop_front();
					if (slope !== exp_fit.slope || intercept !== exp_fit.icpt ||
							rms_residual !== exp_fit.rms || fit_status !== exp_fit.status) begin
						errors++;
						if (errors <= 10)
							$display("mismatch at %0t: exp %h %h %h %0d got %h %h %h %0d",
								$realtime, exp_fit.slope, exp_fit.icpt, exp_fit.rms,
								exp_fit.status, slope, intercept, rms_residual, fit_status);
					end
				end
			end
			if (start && !busy) begin
				if (npts < MAX_POINTS) begin
					w_eff = unit_mode_off ? weight : wlf_pkg::ONE_Q16;
					xl = 64'(x_value);
					yl = 64'(y_value);
					wl = {32'b0, w_eff};
					px[npts] = x_value;
					py[npts] = y_value;
					pw[npts] = w_eff;
					npts = npts + 1;
					acc_w = acc_w + wl;
					acc_wx = acc_wx + ((xl * wl) >>> 16);
					acc_wy = acc_wy + ((yl * wl) >>> 16);
				end
				if (point_last) begin
					fit_queue.push_back(fit_line());
					npts = 0;
					acc_w = 0;
					acc_wx = 0;
					acc_wy = 0;
				end
			end
			pending = fit_queue.size();
		end
	end

endmodule

// ===== dv/tb_weighted_line_fit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_weighted_line_fit: stimulus and verdict for the weighted line fit
// Drives directed and random point sets in both weight modes, with random
// request gaps; the checker beside the block predicts and compares results.
// ----------------------------------------------------------------------------
module tb_weighted_line_fit;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic signed [31:0] x_value = '0;
	logic signed [31:0] y_value = '0;
	logic [31:0]        weight = '0;
	logic               point_last = 1'b0;
	logic               cfg_valid = 1'b0;
	logic               cfg_data = 1'b0;
	logic               busy, cfg_ready, done;
	logic signed [31:0] slope, intercept;
	logic [31:0]        rms_residual;
	logic [1:0]         fit_status;
	int                 errors, pending;
	int                 sent;
	bit                 calm;

	always #5 clk = ~clk;

	weighted_line_fit u_top (.*);

	wlf_checker u_chk (.*);

	// hard stop
	initial begin
		#20ms;
		$display("CHECK FAILED");
		$finish;
	end

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			2: return 32'($signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000);
			default: return 32'($signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000);
		endcase
	endfunction

	function automatic logic [31:0] rand_weight();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return 32'h0;
			2: return wlf_pkg::ONE_Q16;
			3: return 32'hFFFF_FFFF;
			default: return $urandom_range(1, 32'h0004_0000);
		endcase
	endfunction

	// one point request, optionally preceded by an idle burst
	task automatic send_point(input logic [31:0] xv, input logic [31:0] yv,
			input logic [31:0] wv, input logic lastv);
		if (!calm && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		start <= 1'b1;
		x_value <= xv;
		y_value <= yv;
		weight <= wv;
		point_last <= lastv;
		do @(posedge clk); while (busy);
		sent++;
	endtask

	task automatic end_request();
		start <= 1'b0;
		point_last <= 1'b0;
	endtask

	// drain results, then write the weight mode
	task automatic set_mode(input logic v);
		end_request();
		@(posedge clk);
		while (busy || pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// random set of a given size and a random shape
	task automatic send_set(input int n);
		logic [31:0] a, b, xv, yv;
		int          shape;
		shape = $urandom_range(0, 4);
		a = 32'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
		b = rand_coord();
		for (int i = 0; i < n; i++) begin
			xv = (shape == 3) ? b : rand_coord();
			if (shape <= 1) begin
				xv = 32'($signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000);
				yv = 32'(((64'(signed'(a)) * 64'(signed'(xv))) >>> 16) + (b >>> 8)
					+ $urandom_range(0, shape * 255));
			end else begin
				yv = rand_coord();
			end
			send_point(xv, yv, rand_weight(), i == n - 1);
		end
	endtask

	initial begin
		int n;
		sent = 0;
		calm = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes in unit mode, weight field ignored
		send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 1'b0);
		send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0);
		send_point(32'h0, 32'h0, 32'h1234_5678, 1'b1);
		// single point: zero spread
		send_point(32'h0001_0000, 32'h0002_0000, 32'h0, 1'b1);
		// equal x: zero spread
		send_point(32'h0003_0000, 32'h0001_0000, 32'h0, 1'b0);
		send_point(32'h0003_0000, 32'hFFFF_0000, 32'h0, 1'b1);
		// exact line
		send_point(32'h0, 32'h0001_0000, 32'h0, 1'b0);
		send_point(32'h0001_0000, 32'h0003_0000, 32'h0, 1'b0);
		send_point(32'h0002_0000, 32'h0005_0000, 32'h0, 1'b1);
		set_mode(1'b1);
		// zero weight sum
		send_point(32'h0001_0000, 32'h0001_0000, 32'h0, 1'b0);
		send_point(32'h0002_0000, 32'h0004_0000, 32'h0, 1'b1);
		// extreme weights
		send_point(32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0);
		send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 1'b0);
		send_point(32'h0, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1);
		// steep slope saturates
		send_point(32'h0, 32'h8000_0000, wlf_pkg::ONE_Q16, 1'b0);
		send_point(32'h0000_0001, 32'h7FFF_FFFF, wlf_pkg::ONE_Q16, 1'b1);
		// zero weight on one point only
		send_point(32'h0005_0000, 32'h0, 32'h0, 1'b0);
		send_point(32'h0001_0000, 32'h0002_0000, 32'h0002_0000, 1'b0);
		send_point(32'hFFFF_0000, 32'h0001_0000, 32'h0000_8000, 1'b1);
		set_mode(1'b0);

		// random sets, mode rewritten at random between some of the sets
		while (sent < 820) begin
			if (sent > 690) calm = 1'b1;
			n = $urandom_range(0, 39) == 0 ? $urandom_range(63, 67) : $urandom_range(1, 10);
			send_set(n);
			if ($urandom_range(0, 9) == 0) set_mode(1'($urandom_range(0, 1)));
		end
		set_mode(1'b1);
		send_set(3);
		set_mode(1'b0);
		end_request();

		// drain and settle
		while (pending != 0) @(posedge clk);
		repeat (3000) @(posedge clk);
		if (errors == 0 && pending == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/wlf_pkg.sv
rtl/core/wlf_mul.sv
rtl/core/wlf_div.sv
rtl/core/weighted_line_fit.sv
dv/wlf_checker.sv
dv/tb_weighted_line_fit.sv
